/* hdl/touch_report_decoder_top_assert.svh */
// Assertion macros used by the touch report decoder back end.
`ifndef TOUCH_REPORT_DECODER_TOP_ASSERT_SVH
`define TOUCH_REPORT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TRD_ASSERT(label, prop, msg)
`define TRD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/trd_pkg.sv */
// Types and constants of the touch report decoder.
package trd_pkg;

	localparam int PANEL_WIDTH  = 320;
	localparam int PANEL_HEIGHT = 480;
	localparam int COORD_W      = 12;
	localparam int POS_W        = 9;

	localparam logic [COORD_W-1:0] W_MAX = COORD_W'(PANEL_WIDTH - 1);
	localparam logic [COORD_W-1:0] H_MAX = COORD_W'(PANEL_HEIGHT - 1);

	localparam logic [1:0] FUNC_REPORT = 2'd0;
	localparam logic [1:0] FUNC_ERROR  = 2'd1;
	localparam logic [1:0] FUNC_PROBE  = 2'd2;

	localparam logic [1:0] ORIENT_CCW    = 2'd0;
	localparam logic [1:0] ORIENT_CW     = 2'd1;
	localparam logic [1:0] ORIENT_DIRECT = 2'd2;
	localparam logic [1:0] ORIENT_180    = 2'd3;

	localparam logic [1:0] CFG_ORIENTATION = 2'd0;
	localparam logic [1:0] CFG_GRACE_MS    = 2'd1;
	localparam logic [1:0] CFG_ERROR_LIMIT = 2'd2;

	localparam logic [15:0] GRACE_RESET = 16'd60;
	localparam logic [7:0]  LIMIT_RESET = 8'd50;
	localparam logic [7:0]  ERR_MAX     = 8'd255;

	typedef enum logic [1:0] {
		KIND_REPORT,
		KIND_ERROR,
		KIND_PROBE
	} kind_t;

	typedef struct packed {
		logic [1:0]  orientation;
		logic [15:0] grace_ms;
		logic [7:0]  error_limit;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic             touch;
		logic [1:0]       points;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [7:0]       gesture;
		logic [31:0]      now_ms;
		logic             clear_err;
	} item_t;

	typedef struct packed {
		logic             pressed;
		logic [1:0]       point_count;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [7:0]       gesture;
		logic             event_available;
		logic             recovery_request;
	} result_t;

endpackage

/* hdl/trd_front.sv */
// Front end: classifies each poll beat, clamps and rotates the coordinates.
module trd_front import trd_pkg::*; (
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic [1:0]  orientation,
	output item_t       item
);

	logic [7:0]         count_byte;
	logic [COORD_W-1:0] raw_x;
	logic [COORD_W-1:0] raw_y;
	logic [COORD_W-1:0] tx;
	logic [COORD_W-1:0] ty;
	logic [COORD_W-1:0] lx;
	logic [COORD_W-1:0] ly;

	assign count_byte = s_tdata[15:8];
	assign raw_x      = {s_tdata[19:16], s_tdata[31:24]};
	assign raw_y      = {s_tdata[35:32], s_tdata[47:40]};
	assign tx         = (raw_x > W_MAX) ? W_MAX : raw_x;
	assign ty         = (raw_y > H_MAX) ? H_MAX : raw_y;

	always_comb begin
		case (orientation)
			ORIENT_CW: begin
				lx = H_MAX - ty;
				ly = tx;
			end
			ORIENT_DIRECT: begin
				lx = tx;
				ly = ty;
			end
			ORIENT_180: begin
				lx = W_MAX - tx;
				ly = H_MAX - ty;
			end
			default: begin
				lx = ty;
				ly = W_MAX - tx;
			end
		endcase
	end

	always_comb begin
		case (s_tuser)
			FUNC_REPORT: item.kind = KIND_REPORT;
			FUNC_ERROR:  item.kind = KIND_ERROR;
			default:     item.kind = KIND_PROBE;
		endcase
		item.touch     = (count_byte == 8'd1) || (count_byte == 8'd2);
		item.points    = count_byte[1:0];
		item.pos_x     = lx[POS_W-1:0];
		item.pos_y     = ly[POS_W-1:0];
		item.gesture   = s_tdata[7:0];
		item.now_ms    = s_tdata[79:48];
		item.clear_err = (s_tuser == FUNC_PROBE) && s_tdata[80];
	end

endmodule

/* hdl/trd_queue.sv */
// Two-entry queue between the front end and the state update.
module trd_queue import trd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  avail,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign avail    = (count_q != 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hdl/trd_back.sv */
// Back end: press, grace, error and release state with the result register.
module trd_back import trd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    avail,
	input  item_t   item,
	output logic    pop,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t result
);

`include "touch_report_decoder_top_assert.svh"

	logic [1:0]       points_q;
	logic [POS_W-1:0] x_q;
	logic [POS_W-1:0] y_q;
	logic [7:0]       gesture_q;
	logic [31:0]      last_q;
	logic [7:0]       err_q;
	logic             was_q;
	logic             valid_q;
	result_t          result_q;

	logic [1:0]       points_n;
	logic [POS_W-1:0] x_n;
	logic [POS_W-1:0] y_n;
	logic [7:0]       gesture_n;
	logic [31:0]      last_n;
	logic [7:0]       err_n;
	logic [7:0]       err_inc;
	logic             was_n;
	logic             prs;
	logic             evt;
	logic             rec;
	logic             was_eff;
	logic [31:0]      elapsed;

	assign pop      = avail && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign result   = result_q;
	assign elapsed  = item.now_ms - last_q;
	assign err_inc  = (err_q != ERR_MAX) ? err_q + 8'd1 : err_q;

	always_comb begin
		points_n  = points_q;
		x_n       = x_q;
		y_n       = y_q;
		gesture_n = gesture_q;
		last_n    = last_q;
		err_n     = err_q;
		was_n     = was_q;
		prs       = (points_q != 2'd0);
		evt       = 1'b0;
		rec       = 1'b0;
		was_eff   = was_q;
		case (item.kind)
			KIND_REPORT: begin
				err_n     = 8'd0;
				gesture_n = item.gesture;
				if (item.touch) begin
					points_n = item.points;
					last_n   = item.now_ms;
					x_n      = item.pos_x;
					y_n      = item.pos_y;
					prs      = 1'b1;
				end else if ((points_q != 2'd0) && (elapsed < {16'd0, cfg.grace_ms})) begin
					prs = 1'b1;
				end else begin
					points_n = 2'd0;
					prs      = 1'b0;
				end
				if (was_q && !prs) begin
					was_n = 1'b0;
					evt   = 1'b1;
				end else begin
					was_n = prs;
					evt   = prs;
				end
			end
			KIND_ERROR: begin
				err_n    = err_inc;
				rec      = (err_inc >= cfg.error_limit);
				was_eff  = rec ? 1'b0 : was_q;
				points_n = 2'd0;
				prs      = 1'b0;
				evt      = was_eff;
				was_n    = 1'b0;
			end
			KIND_PROBE: begin
				if (item.clear_err) begin
					err_n = 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.pressed          <= prs;
			result_q.point_count      <= points_n;
			result_q.pos_x            <= x_n;
			result_q.pos_y            <= y_n;
			result_q.gesture          <= gesture_n;
			result_q.event_available  <= evt;
			result_q.recovery_request <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q  <= 2'd0;
			x_q       <= '0;
			y_q       <= '0;
			gesture_q <= 8'd0;
			last_q    <= 32'd0;
			err_q     <= 8'd0;
			was_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				points_q  <= points_n;
				x_q       <= x_n;
				y_q       <= y_n;
				gesture_q <= gesture_n;
				last_q    <= last_n;
				err_q     <= err_n;
				was_q     <= was_n;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	`TRD_ASSERT(a_recovery_no_press,
		valid_q && result_q.recovery_request |-> !result_q.pressed && !result_q.event_available,
		"recovery request shown together with a press or an event")
	`TRD_ASSERT(a_press_has_points,
		valid_q && result_q.pressed |-> result_q.point_count != 2'd0,
		"press shown without held points")
	`TRD_ASSERT_NEXT(a_error_counts, pop && item.kind == KIND_ERROR,
		err_q != 8'd0 && points_q == 2'd0 && !was_q,
		"transfer error left the count at zero or a press held")

endmodule

/* hdl/touch_report_decoder_top.sv */
// Top level of the touch report decoder: ports, configuration registers, front, queue, back.

// One poll outcome enters per beat and each gives exactly one result beat; the block
// sustains one beat per clock cycle while m_tready is high. The classify, clamp and
// rotate logic feeds a two-entry queue, and the state update with its result register
// takes one queued beat per cycle while m_tready is high, so a poll beat passes through
// a queue entry and then the result register, and the front keeps accepting while a
// result waits until the queue is full. Configuration writes take effect at once and
// belong in idle periods. Writes to an index beyond the three registers are ignored.
module touch_report_decoder_top import trd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// gesture_byte, count_byte, x_high, x_low, y_high, y_low, now_ms, probe_ok, zero fill
	input  logic [87:0] s_tdata,
	// func
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pressed, point_count, pos_x, pos_y, gesture, event_available, recovery_request, zero fill
	output logic [31:0] m_tdata
);

	cfg_t    cfg_q;
	item_t   front_item;
	item_t   queue_item;
	result_t result;
	logic    queue_full;
	logic    queue_avail;
	logic    queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation <= ORIENT_CCW;
			cfg_q.grace_ms    <= GRACE_RESET;
			cfg_q.error_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ORIENTATION: cfg_q.orientation <= cfg_wdata[1:0];
				CFG_GRACE_MS:    cfg_q.grace_ms    <= cfg_wdata;
				CFG_ERROR_LIMIT: cfg_q.error_limit <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !queue_full;

	trd_front u_front (
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.orientation (cfg_q.orientation),
		.item        (front_item)
	);

	trd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.avail     (queue_avail),
		.pop_item  (queue_item)
	);

	trd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.avail    (queue_avail),
		.item     (queue_item),
		.pop      (queue_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result)
	);

	assign m_tdata = {1'b0, result.recovery_request, result.event_available, result.gesture,
		result.pos_y, result.pos_x, result.point_count, result.pressed};

endmodule
